// ----- hdl/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
// No dependencies; every other file in the block imports this package.
package tli_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int DATA_W          = 32;
	localparam int INDEX_W         = 6;
	localparam int PIU_W           = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_POINTS_IN_USE = 1'b0;

	typedef struct packed {
		logic                     operation;
		logic [INDEX_W-1:0]       point_index;
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

// ----- hdl/tli_front.sv -----
// Input side of the interpolator: takes transfers and holds them in a short queue.
// Depends on tli_pkg.
module tli_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [tli_pkg::INDEX_W-1:0]       point_index,
	input  logic signed [tli_pkg::DATA_W-1:0] x_value,
	input  logic signed [tli_pkg::DATA_W-1:0] y_value,
	output tli_pkg::queue_head_t              head,
	input  logic                              pop
);
	import tli_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          do_pop;

	assign in_ready = (count_q != CW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= '{operation, point_index, x_value, y_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/tli_back.sv -----
// Execution side: breakpoint tables, binary search, serial divider and multiplier.
// Depends on tli_pkg; fed from the queue in tli_front.
module tli_back #(
	parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
	parameter int FRAC_BITS   = tli_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tli_pkg::queue_head_t              head,
	output logic                              pop,
	input  logic [tli_pkg::PIU_W-1:0]         points_in_use,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tli_pkg::DATA_W-1:0] y_result
);
	import tli_pkg::*;

	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW  = $clog2(TABLE_DEPTH + 1);
	localparam int CNW = $clog2(FRAC_BITS + 1);
	localparam int QW  = FRAC_BITS + 1;
	localparam int PRW = DATA_W + 1 + QW;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_FIRST  = 10'b0000000010,
		S_LAST   = 10'b0000000100,
		S_SEARCH = 10'b0000001000,
		S_CMP    = 10'b0000010000,
		S_SEGA   = 10'b0000100000,
		S_SEGB   = 10'b0001000000,
		S_DIV    = 10'b0010000000,
		S_MUL    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	logic [DATA_W-1:0] mem_x [TABLE_DEPTH];
	logic [DATA_W-1:0] mem_y [TABLE_DEPTH];
	logic [DATA_W-1:0] rd_x_q;
	logic [DATA_W-1:0] rd_y_q;
	logic [IW-1:0]     rd_addr;

	state_t                   state_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] xa_q;
	logic signed [DATA_W-1:0] ya_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            lo_q;
	logic [NW-1:0]            hi_q;
	logic [NW:0]              mid;
	logic [DATA_W-1:0]        den_q;
	logic [DATA_W:0]          rem_q;
	logic [QW-1:0]            quo_q;
	logic [CNW-1:0]           cnt_q;
	logic signed [PRW-1:0]    acc_q;
	logic signed [PRW-1:0]    mcand_q;
	logic [QW-1:0]            mplier_q;
	logic signed [DATA_W-1:0] res_q;

	logic [NW-1:0]            n_eff;
	logic                     wr_en;
	logic signed [DATA_W-1:0] rx;
	logic signed [DATA_W-1:0] ry;
	logic signed [DATA_W:0]   dx;
	logic signed [DATA_W:0]   dy;
	logic [DATA_W-1:0]        num;
	logic [DATA_W:0]          trial;
	logic                     qbit;
	logic [QW-1:0]            quo_next;
	logic                     last_step;
	logic signed [PRW-1:0]    scaled;

	assign rx = $signed(rd_x_q);
	assign ry = $signed(rd_y_q);

	// Points in use outside 1..TABLE_DEPTH are pulled to the nearest end.
	always_comb begin
		if ({25'd0, points_in_use} > 32'(TABLE_DEPTH)) begin
			n_eff = NW'(TABLE_DEPTH);
		end else if (points_in_use == '0) begin
			n_eff = NW'(1);
		end else begin
			n_eff = NW'(points_in_use);
		end
	end

	assign mid  = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign pop  = (state_q == S_IDLE) && head.valid;
	assign wr_en = pop && (head.item.operation == OP_WRITE)
		&& ({26'd0, head.item.point_index} < 32'(TABLE_DEPTH));

	always_comb begin
		case (state_q)
			S_FIRST:  rd_addr = IW'(n_q - 1'b1);
			S_SEARCH: rd_addr = ((hi_q - lo_q) > NW'(1)) ? IW'(mid[NW-1:0] - 1'b1)
			                                             : IW'(lo_q - 1'b1);
			S_SEGA:   rd_addr = IW'(lo_q);
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[IW'(head.item.point_index)] <= head.item.x_value;
			mem_y[IW'(head.item.point_index)] <= head.item.y_value;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	// Segment arithmetic, used when the second point of the segment arrives.
	always_comb begin
		dx = {x_q[DATA_W-1], x_q} - {xa_q[DATA_W-1], xa_q};
		dy = {ry[DATA_W-1], ry} - {ya_q[DATA_W-1], ya_q};
		if (dx[DATA_W]) begin
			num = '0;
		end else if (dx[DATA_W-1:0] > DATA_W'(rx - xa_q)) begin
			num = DATA_W'(rx - xa_q);
		end else begin
			num = dx[DATA_W-1:0];
		end
	end

	// One quotient bit per cycle; the first step takes the remainder unshifted.
	always_comb begin
		trial     = (cnt_q == '0) ? rem_q : (rem_q << 1);
		qbit      = (trial >= {1'b0, den_q});
		quo_next  = {quo_q[QW-2:0], qbit};
		last_step = (cnt_q == CNW'(FRAC_BITS));
		scaled    = acc_q >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q <= head.item.x_value;
				n_q <= n_eff;
			end
			S_FIRST: begin
				res_q <= ry;
			end
			S_LAST: begin
				res_q <= ry;
				lo_q  <= NW'(1);
				hi_q  <= n_q;
			end
			S_CMP: begin
				if (x_q > rx) begin
					lo_q <= mid[NW-1:0];
				end else begin
					hi_q <= mid[NW-1:0];
				end
			end
			S_SEGA: begin
				xa_q <= rx;
				ya_q <= ry;
			end
			S_SEGB: begin
				res_q   <= ya_q;
				den_q   <= DATA_W'(rx - xa_q);
				rem_q   <= {1'b0, num};
				quo_q   <= '0;
				mcand_q <= PRW'(dy);
			end
			S_DIV: begin
				rem_q <= qbit ? (trial - {1'b0, den_q}) : trial;
				quo_q <= quo_next;
				if (last_step) begin
					mplier_q <= quo_next;
					acc_q    <= '0;
				end
			end
			S_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				if (last_step) begin
					res_q <= ya_q + DATA_W'(mplier_q[0] ? ((acc_q + mcand_q) >>> FRAC_BITS)
					                                    : scaled);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && (head.item.operation == OP_QUERY)) begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					state_q <= (x_q < rx) ? S_OUT : S_LAST;
				end
				S_LAST: begin
					state_q <= ((x_q > rx) || (n_q == NW'(1))) ? S_OUT : S_SEARCH;
				end
				S_SEARCH: begin
					state_q <= ((hi_q - lo_q) > NW'(1)) ? S_CMP : S_SEGA;
				end
				S_CMP: begin
					state_q <= S_SEARCH;
				end
				S_SEGA: begin
					state_q <= S_SEGB;
				end
				S_SEGB: begin
					cnt_q   <= '0;
					state_q <= (rx <= xa_q) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (last_step) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL: begin
					if (last_step) begin
						cnt_q   <= '0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign y_result  = res_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("queue popped while a query is in progress");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (lo_q < hi_q))
		else $error("search bounds crossed");
	a_segment_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEGA) |-> (hi_q == lo_q + 1'b1))
		else $error("segment found with non-adjacent bounds");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q <= {1'b0, den_q}))
		else $error("divider remainder exceeds divisor");

endmodule

// ----- hdl/table_linear_interpolator_unit.sv -----
// Piecewise-linear lookup table. A table write is done as the item is taken, while idle.
// A query is worked by the binary search over the table RAM port, then the bit-serial
// divider and the shift-add multiplier; when x lies outside the table, the first or last
// y value is the result and the search is skipped. One query is worked at a time and the
// next item is taken the cycle after the result transfer. Reset clears control state and
// sets points_in_use to 1; table contents are not cleared and are undefined until written.
module table_linear_interpolator_unit #(
	parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
	parameter int FRAC_BITS   = tli_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [tli_pkg::INDEX_W-1:0]       point_index,
	input  logic signed [tli_pkg::DATA_W-1:0] x_value,
	input  logic signed [tli_pkg::DATA_W-1:0] y_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tli_pkg::DATA_W-1:0] y_result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import tli_pkg::*;

	// The front end queues every transfer so that a new item can be taken
	// while the back end is busy or its result has not yet been collected.
	queue_head_t          head;
	logic                 pop;
	logic [PIU_W-1:0]     points_in_use_q;
	logic                 reg_sel;

	// Only one register exists; bit 2 of the byte address selects beyond it.
	assign reg_sel = (paddr[2] == REG_POINTS_IN_USE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {25'd0, points_in_use_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= PIU_W'(1);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			points_in_use_q <= pwdata[PIU_W-1:0];
		end
	end

	tli_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.point_index (point_index),
		.x_value     (x_value),
		.y_value     (y_value),
		.head        (head),
		.pop         (pop)
	);

	// The back end holds the tables and does the search and arithmetic; its
	// result register stays valid until the downstream side takes the transfer.
	tli_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.points_in_use (points_in_use_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.y_result      (y_result)
	);

endmodule

// ----- tb/table_linear_interpolator_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for table_linear_interpolator_unit: table loads and queries
// with a scoreboard that keeps its own copy of the table. Depends on tli_pkg and the RTL.
module table_linear_interpolator_unit_tb;
	import tli_pkg::*;

	// Scoreboard: a private copy of the breakpoint table and the point count,
	// and the queue of results still owed by the block.
	class interp_scoreboard;
		logic [31:0] bx [64];
		logic [31:0] by [64];
		bit          written [64];
		logic [6:0]  points_reg;
		logic [31:0] owed_results [$];
		int          errors;

		function new();
			points_reg = 7'd1;
			errors = 0;
			foreach (written[i]) written[i] = 0;
		endfunction

		function int active_points();
			if (points_reg < 1) return 1;
			if (points_reg > 64) return 64;
			return points_reg;
		endfunction

		// True once every entry that a query may visit has been loaded.
		function bit table_ready();
			for (int i = 0; i < active_points(); i++)
				if (!written[i]) return 0;
			return 1;
		endfunction

		function logic [31:0] interpolate(logic [31:0] xq);
			int     n, lo, hi, mid, seg;
			longint xs, xa, xb, ya, yb, res, num, den, w;
			n = active_points();
			xs = longint'($signed(xq));
			if (xs < longint'($signed(bx[0]))) seg = 0;
			else if (xs > longint'($signed(bx[n-1]))) seg = n;
			else begin
				lo = 1;
				hi = n;
				while (hi - lo > 1) begin
					mid = (lo + hi) / 2;
					if (xs > longint'($signed(bx[mid-1]))) lo = mid;
					else hi = mid;
				end
				seg = lo;
			end
			if (seg == 0) res = longint'($signed(by[0]));
			else if (seg >= n) res = longint'($signed(by[n-1]));
			else begin
				xa = longint'($signed(bx[seg-1]));
				xb = longint'($signed(bx[seg]));
				ya = longint'($signed(by[seg-1]));
				yb = longint'($signed(by[seg]));
				if (xb <= xa) res = ya;
				else begin
					num = xs - xa;
					den = xb - xa;
					if (xs < xa) num = 0;
					if (num > den) num = den;
					w = (num << FRAC_BITS_DEF) / den;
					// The arithmetic shift floors towards minus infinity.
					res = ya + ((w * (yb - ya)) >>> FRAC_BITS_DEF);
				end
			end
			return res[31:0];
		endfunction

		function void note_input(logic op, logic [5:0] idx, logic [31:0] xv, logic [31:0] yv);
			if (op == OP_WRITE) begin
				bx[idx] = xv;
				by[idx] = yv;
				written[idx] = 1;
			end else
				owed_results.push_back(interpolate(xv));
		endfunction

		function void check_result(logic [31:0] got);
			logic [31:0] want;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result y_result=%h", got);
				return;
			end
			want = owed_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("y_result mismatch: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        operation = OP_WRITE;
	logic [5:0]  point_index = '0;
	logic signed [31:0] x_value = '0;
	logic signed [31:0] y_value = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic signed [31:0] y_result;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	interp_scoreboard lut_sb = new();
	bit idling_on = 1;   // random gaps and stalls on both sides
	int hold_cycles = 0; // long receiver hold-off requested by the stimulus

	table_linear_interpolator_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// The run ends here if the block stops making progress.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: ready is driven on the falling edge, with random stall bursts and
	// an occasional long hold-off that lets the block fill up and stall its input.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				stall_left = $urandom_range(0, 4);
			end else
				out_ready <= 1;
		end
	end

	// Every result transfer is checked against the oldest owed value.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) lut_sb.check_result(y_result);

	// Offers one item and returns once its transfer has taken place. Valid is only
	// lowered when an idle burst is due, so back-to-back items keep it high.
	task automatic send_item(logic op, logic [5:0] idx, logic [31:0] xv, logic [31:0] yv);
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1;
		operation   <= op;
		point_index <= idx;
		x_value     <= xv;
		y_value     <= yv;
		do @(posedge clk); while (!in_ready);
		lut_sb.note_input(op, idx, xv, yv);
	endtask

	// Waits until the block is idle: all results in, then enough cycles for a
	// trailing table write to finish.
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (lut_sb.owed_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_points(logic [6:0] value);
		drain();
		@(negedge clk);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= 3'(4 * REG_POINTS_IN_USE);
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		lut_sb.points_reg = value;
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
	endtask

	// Loads the active entries with ascending x, mixing zero-width segments and
	// steps of very different size. With span_all the table runs from the most
	// negative to the most positive x.
	task automatic load_ascending(bit span_all);
		int     n;
		longint xv;
		n = lut_sb.active_points();
		xv = span_all ? -64'sd2147483648 : longint'($signed($urandom)) >>> $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			if (span_all && i == n - 1 && n > 1) xv = 64'sd2147483647;
			send_item(OP_WRITE, 6'(i), xv[31:0], $urandom);
			case ($urandom_range(0, 3))
				0: xv += 0;
				1: xv += $urandom_range(1, 16);
				2: xv += $urandom_range(1, 1 << 16);
				default: xv += $urandom_range(1, 1 << 26);
			endcase
			if (xv > 64'sd2147483647) xv = 64'sd2147483647;
		end
	endtask

	// A query aimed near a breakpoint, inside a segment, or anywhere at all.
	task automatic random_query();
		int          k, n;
		logic [31:0] xq;
		n = lut_sb.active_points();
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 4))
			0: xq = lut_sb.bx[k];
			1: xq = lut_sb.bx[k] + 32'($urandom_range(0, 600)) - 32'd300;
			2: xq = 32'((longint'($signed(lut_sb.bx[k]))
				+ longint'($signed(lut_sb.bx[(k + 1) % n]))) / 2);
			default: xq = $urandom;
		endcase
		send_item(OP_QUERY, 6'($urandom), xq, $urandom);
	endtask

	initial begin
		logic [6:0] setting [8];
		int         n;

		setting = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd65, 7'd1, 7'd64};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed part: a single point first, then a short table with a zero-width
		// segment and y values at both extremes.
		send_item(OP_WRITE, 6'd0, 32'h0001_0000, 32'h0005_0000);
		send_item(OP_QUERY, 6'd63, 32'h8000_0000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h7fff_ffff, 32'hffff_ffff);
		send_item(OP_QUERY, 6'd0, 32'h0001_0000, 32'h0);
		write_points(7'd4);
		send_item(OP_WRITE, 6'd1, 32'h0002_0000, 32'h8000_0000);
		send_item(OP_WRITE, 6'd2, 32'h0002_0000, 32'h7fff_ffff);
		send_item(OP_WRITE, 6'd3, 32'h0010_0000, 32'hfffe_0000);
		send_item(OP_QUERY, 6'd0, 32'h8000_0000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h7fff_ffff, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0001_8000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0002_0000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0001_0000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0010_0000, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0008_1234, 32'h0);
		send_item(OP_QUERY, 6'd0, 32'h0001_0001, 32'h0);

		// Random part: each phase sets the point count, reloads an ascending table
		// and then mixes queries with stray writes that may break the ordering.
		for (int p = 0; p < 8; p++) begin
			if (p == 7) idling_on = 0;
			write_points(p == 4 ? 7'($urandom_range(3, 63)) : setting[p]);
			load_ascending(p == 1 || p == 5);
			if (p == 2) hold_cycles = 300;
			for (int i = 0; i < 70; i++) begin
				n = lut_sb.active_points();
				if ($urandom_range(0, 9) == 0)
					send_item(OP_WRITE, 6'($urandom), $urandom, $urandom);
				else if (lut_sb.table_ready())
					random_query();
				else begin
					// An entry in use was never loaded: load it before querying.
					for (int k = 0; k < n; k++)
						if (!lut_sb.written[k]) begin
							send_item(OP_WRITE, 6'(k), $urandom, $urandom);
							break;
						end
				end
			end
		end

		@(negedge clk);
		in_valid <= 0;
		while (lut_sb.owed_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (lut_sb.errors == 0 && lut_sb.owed_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/tli_pkg.sv
hdl/tli_front.sv
hdl/tli_back.sv
hdl/table_linear_interpolator_unit.sv
tb/table_linear_interpolator_unit_tb.sv
